/* sv/bounded_keyed_list_engine_defines.svh */
// Assertion macros used by the list engine.
`ifndef BOUNDED_KEYED_LIST_ENGINE_DEFINES_SVH
`define BOUNDED_KEYED_LIST_ENGINE_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define BKLE_ASSERT_IMP(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define BKLE_ASSERT_NXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);
`endif

/* sv/bkle_pkg.sv */
package bkle_pkg;

    localparam int unsigned CAPACITY_DEF = 64;

    localparam logic [2:0] OP_INS_FRONT = 3'd0;
    localparam logic [2:0] OP_INS_BACK  = 3'd1;
    localparam logic [2:0] OP_REM_FRONT = 3'd2;
    localparam logic [2:0] OP_REM_BACK  = 3'd3;
    localparam logic [2:0] OP_FIND      = 3'd4;
    localparam logic [2:0] OP_INS_AFTER = 3'd5;
    localparam logic [2:0] OP_UNUSED_A  = 3'd6;
    localparam logic [2:0] OP_UNUSED_B  = 3'd7;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_NOKEY = 2'd3;

endpackage

/* sv/bkle_store.sv */
// Entry memory: key, weight and link, one write port and one registered read port.
module bkle_store #(
    parameter int unsigned CAPACITY = bkle_pkg::CAPACITY_DEF,
    localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [IW-1:0] i_waddr,
    input  logic [31:0]   i_wkey,
    input  logic [31:0]   i_wwt,
    input  logic [IW-1:0] i_wlink,
    input  logic [IW-1:0] i_raddr,
    output logic [31:0]   o_rkey,
    output logic [31:0]   o_rwt,
    output logic [IW-1:0] o_rlink
);
    logic [31+32+IW:0] mem [CAPACITY];
    logic [31+32+IW:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= {i_wkey, i_wwt, i_wlink};
        end
        r_rd <= mem[i_raddr];
    end

    assign o_rkey  = r_rd[32+32+IW-1 -: 32];
    assign o_rwt   = r_rd[32+IW-1 -: 32];
    assign o_rlink = r_rd[IW-1:0];
endmodule

/* sv/bounded_keyed_list_engine.sv */
// Bounded keyed list engine: an ordered singly linked list of up to CAPACITY
// entries, each a key and an opaque weight word.
// Requests arrive on the s_axis channel (operation, match key, entry key and
// weight packed in s_axis_tdata); one result per request leaves on m_axis
// (status, key, weight, count and empty flag packed in m_axis_tdata).
// The block handles one request at a time and is not ready while it works.
// Inserts at the front need no entry read, while removals from the front are
// paced by the entry memory, whose reads are registered.
// Find, insert-after and remove-from-back walk the links one entry per cycle
// through that same memory read port, so the link walk sets the worst case.
// Reset clears the control state and refills the free-index stack, which is
// swept one entry per cycle: after reset the block accepts no request until
// the sweep is done. The entry memory itself is never cleared.
// A finished result sits in an output register; while the receiver stalls
// the block holds that result and takes no new request.
// Entry count is the held count taken modulo 128.
`include "bounded_keyed_list_engine_defines.svh"
module bounded_keyed_list_engine #(
    parameter int unsigned CAPACITY = bkle_pkg::CAPACITY_DEF,
    localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [2:0] operation, [34:3] match_key, [66:35] entry_key,
    // [98:67] entry_weight, [103:99] zero
    input  logic [103:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [1:0] status, [33:2] out_key, [65:34] out_weight,
    // [72:66] entry_count, [73] is_empty, [79:74] zero
    output logic [79:0]  m_axis_tdata
);
    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DECODE, S_RDHEAD, S_WALK, S_INSLINK,
        S_INSWR, S_INSAFT, S_OUT
    } t_state;

    t_state r_state;
    logic [2:0]    r_op;
    logic [31:0]   r_mkey, r_ekey, r_ewt;
    logic [IW-1:0] r_head, r_tail, r_cur, r_pos, r_slot, r_clr;
    logic [CW-1:0] r_count, r_n;
    logic [1:0]    r_status;
    logic [31:0]   r_okey, r_owt;
    logic          r_rdwait;

    // free-index stack, its own memory
    logic [IW-1:0] free_mem [CAPACITY];
    logic [IW-1:0] r_free_top;
    logic          fs_we;
    logic [IW-1:0] fs_waddr, fs_wdata, fs_raddr;

    // entry memory port
    logic          st_we;
    logic [IW-1:0] st_waddr, st_wlink, st_raddr;
    logic [31:0]   st_wkey, st_wwt;
    logic [31:0]   st_rkey, st_rwt;
    logic [IW-1:0] st_rlink;

    bkle_store #(.CAPACITY(CAPACITY)) u_store (
        .i_clk(i_clk), .i_we(st_we), .i_waddr(st_waddr), .i_wkey(st_wkey),
        .i_wwt(st_wwt), .i_wlink(st_wlink), .i_raddr(st_raddr),
        .o_rkey(st_rkey), .o_rwt(st_rwt), .o_rlink(st_rlink)
    );

    always_ff @(posedge i_clk) begin
        if (fs_we) begin
            free_mem[fs_waddr] <= fs_wdata;
        end
        r_free_top <= free_mem[fs_raddr];
    end

    logic full, empty;
    assign full  = (r_count == CW'(CAPACITY));
    assign empty = (r_count == '0);
    assign fs_raddr = r_count[IW-1:0];

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata = {6'd0, empty, 7'(r_count), r_owt, r_okey, r_status};

    // combinational memory controls
    always_comb begin
        st_we = 1'b0; st_waddr = r_slot; st_wkey = r_ekey; st_wwt = r_ewt;
        st_wlink = r_head; st_raddr = r_cur;
        fs_we = 1'b0; fs_waddr = r_clr; fs_wdata = r_clr;
        case (r_state)
            S_CLEAR: begin
                fs_we = 1'b1;
            end
            S_INSWR: begin
                st_we = 1'b1;
                case (r_op)
                    bkle_pkg::OP_INS_FRONT: st_wlink = r_head;
                    bkle_pkg::OP_INS_AFTER: st_wlink = st_rlink;
                    default:                st_wlink = r_slot;
                endcase
            end
            S_INSLINK, S_INSAFT: begin
                // rewrite the tail (or matched) entry with its new link
                st_we = 1'b1; st_waddr = r_pos; st_wkey = st_rkey;
                st_wwt = st_rwt; st_wlink = r_slot;
            end
            S_WALK: begin
                // On a match for insert-after the matched entry stays on the read port.
                if (r_rdwait || (r_op == bkle_pkg::OP_INS_AFTER && st_rkey == r_mkey)) begin
                    st_raddr = r_cur;
                end else begin
                    st_raddr = st_rlink;
                end
            end
            default: begin
                st_raddr = r_cur;
            end
        endcase
        if (r_state == S_OUT && m_axis_tready &&
            (r_op == bkle_pkg::OP_REM_FRONT || r_op == bkle_pkg::OP_REM_BACK) &&
            r_status == bkle_pkg::ST_OK) begin
            fs_we = 1'b1; fs_waddr = r_count[IW-1:0]; fs_wdata = r_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR; r_clr <= '0; r_head <= '0; r_tail <= '0;
            r_count <= '0; r_rdwait <= 1'b0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == IW'(CAPACITY - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_op <= s_axis_tdata[2:0];
                        r_mkey <= s_axis_tdata[34:3];
                        r_ekey <= s_axis_tdata[66:35];
                        r_ewt <= s_axis_tdata[98:67];
                        r_okey <= '0; r_owt <= '0; r_status <= bkle_pkg::ST_OK;
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    // free-stack top is now read; r_cur starts at head
                    r_slot <= r_free_top; r_cur <= r_head; r_n <= '0;
                    r_rdwait <= 1'b1;
                    case (r_op)
                        bkle_pkg::OP_INS_FRONT: begin
                            if (full) begin
                                r_status <= bkle_pkg::ST_FULL; r_state <= S_OUT;
                            end else r_state <= S_INSWR;
                        end
                        bkle_pkg::OP_INS_BACK: begin
                            if (full) begin
                                r_status <= bkle_pkg::ST_FULL; r_state <= S_OUT;
                            end else if (empty) r_state <= S_INSWR;
                            else begin
                                r_cur <= r_tail; r_pos <= r_tail; r_state <= S_RDHEAD;
                            end
                        end
                        bkle_pkg::OP_REM_FRONT, bkle_pkg::OP_REM_BACK: begin
                            if (empty) begin
                                r_status <= bkle_pkg::ST_EMPTY; r_state <= S_OUT;
                            end else begin
                                if (r_op == bkle_pkg::OP_REM_BACK) r_cur <= r_tail;
                                r_state <= S_RDHEAD;
                            end
                        end
                        bkle_pkg::OP_FIND: begin
                            if (empty) begin
                                r_status <= bkle_pkg::ST_NOKEY; r_state <= S_OUT;
                            end else r_state <= S_WALK;
                        end
                        bkle_pkg::OP_INS_AFTER: begin
                            if (full) begin
                                r_status <= bkle_pkg::ST_FULL; r_state <= S_OUT;
                            end else if (empty) begin
                                r_status <= bkle_pkg::ST_NOKEY; r_state <= S_OUT;
                            end else r_state <= S_WALK;
                        end
                        default: r_state <= S_OUT;
                    endcase
                end
                S_RDHEAD: begin
                    // r_cur is presented while r_rdwait is set; its data is valid once r_rdwait clears
                    if (r_rdwait) r_rdwait <= 1'b0;
                    else begin
                        case (r_op)
                            bkle_pkg::OP_INS_BACK: r_state <= S_INSLINK;
                            bkle_pkg::OP_REM_FRONT: begin
                                r_okey <= st_rkey; r_owt <= st_rwt; r_slot <= r_cur;
                                r_count <= r_count - 1'b1;
                                if (r_count == CW'(1)) begin
                                    r_head <= '0; r_tail <= '0;
                                end else r_head <= st_rlink;
                                r_state <= S_OUT;
                            end
                            default: begin
                                // remove back: tail data captured, then find predecessor
                                r_okey <= st_rkey; r_owt <= st_rwt; r_slot <= r_cur;
                                if (r_count == CW'(1)) begin
                                    r_head <= '0; r_tail <= '0;
                                    r_count <= r_count - 1'b1; r_state <= S_OUT;
                                end else if (r_count == CW'(2)) begin
                                    r_tail <= r_head;
                                    r_count <= r_count - 1'b1; r_state <= S_OUT;
                                end else begin
                                    r_cur <= r_head; r_n <= '0; r_rdwait <= 1'b1;
                                    r_state <= S_WALK;
                                end
                            end
                        endcase
                    end
                end
                S_WALK: begin
                    if (r_rdwait) r_rdwait <= 1'b0;
                    else if (r_op == bkle_pkg::OP_REM_BACK) begin
                        // r_cur holds entry number r_n; predecessor is number count-2
                        if (r_n == r_count - CW'(2)) begin
                            r_tail <= r_cur; r_count <= r_count - 1'b1; r_state <= S_OUT;
                        end else begin
                            r_cur <= st_rlink; r_n <= r_n + 1'b1;
                        end
                    end else if (st_rkey == r_mkey) begin
                        r_pos <= r_cur;
                        if (r_op == bkle_pkg::OP_FIND) begin
                            r_okey <= st_rkey; r_owt <= st_rwt; r_state <= S_OUT;
                        end else r_state <= S_INSWR;
                    end else if (r_n == r_count - CW'(1)) begin
                        r_status <= bkle_pkg::ST_NOKEY; r_state <= S_OUT;
                    end else begin
                        r_cur <= st_rlink; r_n <= r_n + 1'b1;
                    end
                end
                S_INSWR: begin
                    r_count <= r_count + 1'b1;
                    case (r_op)
                        bkle_pkg::OP_INS_FRONT: begin
                            r_head <= r_slot;
                            if (empty) r_tail <= r_slot;
                            r_state <= S_OUT;
                        end
                        bkle_pkg::OP_INS_AFTER: begin
                            if (r_pos == r_tail) r_tail <= r_slot;
                            r_state <= S_INSAFT;
                        end
                        default: begin
                            // back insert: first entry of an empty list, or after link
                            if (empty) r_head <= r_slot;
                            r_tail <= r_slot; r_state <= S_OUT;
                        end
                    endcase
                end
                S_INSLINK: begin
                    r_state <= S_INSWR;
                end
                S_INSAFT: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (m_axis_tready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // The matched entry is still on the read port during S_INSWR and S_INSAFT,
    // so S_INSAFT rewrites it with its link pointing at the new slot.
    logic aft_we;
    assign aft_we = (r_state == S_INSAFT);

    `BKLE_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(CAPACITY),
        "held count above capacity")
    `BKLE_ASSERT_IMP(a_out_empty, i_clk, i_rst_n,
        m_axis_tvalid && r_status == bkle_pkg::ST_EMPTY, r_count == '0,
        "empty status with entries held")
    `BKLE_ASSERT_NXT(a_ready_after, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tready, s_axis_tready, "not ready after result")
    `BKLE_ASSERT_IMP(a_head_tail, i_clk, i_rst_n, r_count == CW'(1) && s_axis_tready,
        r_head == r_tail, "single entry with head unlike tail")
    `BKLE_ASSERT_IMP(a_aft, i_clk, i_rst_n, aft_we, r_op == bkle_pkg::OP_INS_AFTER,
        "link rewrite outside insert-after")
endmodule
